>>> src/gnh_pkg.sv
// Shared types, constants and helpers for the geographic next-hop select unit.
// Used by geographic_next_hop_select_unit; depends on nothing else.
package gnh_pkg;

    localparam int COORD_BITS    = 16;
    localparam int ID_W          = 16;
    localparam int SLOT_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int NEIGHBORS_DEF = 16;

    // Multiplier operand, product and accumulator widths.
    localparam int MW = COORD_BITS + 2;
    localparam int PW = 2 * MW;
    localparam int AW = PW + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_GABRIEL = 2'd2;

    typedef struct packed {
        logic                         opcode;
        logic [SLOT_W-1:0]            slot;
        logic                         entry_valid;
        logic [ID_W-1:0]              entry_id;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
    } gnh_req_t;

    typedef struct packed {
        logic [ID_W-1:0] next_hop;
        logic            found;
        logic            used_perimeter;
    } gnh_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OWN,
        ST_GREEDY,
        ST_G_END,
        ST_PL_D,
        ST_PL_W,
        ST_PER,
        ST_P_END,
        ST_DONE
    } gnh_state_t;

    function automatic logic signed [MW-1:0] ext(input logic signed [COORD_BITS-1:0] v);
        ext = {{2{v[COORD_BITS-1]}}, v};
    endfunction

    function automatic logic signed [AW-1:0] pext(input logic signed [PW-1:0] p);
        pext = {p[PW-1], p};
    endfunction

endpackage

>>> src/geographic_next_hop_select_unit.sv
// Top level of the geographic next-hop select unit: neighbor table, shared
// multiplier datapath and its sequencer. Depends on gnh_pkg.
//
// Usage: request transactions arrive on req/req_valid/req_stall and each
// produces exactly one response transaction on rsp/rsp_valid/rsp_stall.
// A write request loads or clears one table slot; a query returns the
// chosen neighbor id, whether one was found and whether perimeter mode
// decided it. Configuration (own position, planarization mode) is written
// through cfg_we/cfg_index/cfg_data while the unit is idle.
// The unit works on one request at a time and stalls the request side
// until the response has been loaded into the output register. All
// geometry runs through one 18x18 multiplier followed by one accumulator,
// so the latency is set by the number of products per neighbor. A write
// only updates the table; a greedy query scans every slot once; a
// perimeter query adds a planarization pass that tests each usable slot
// against every other usable slot, then a counterclockwise scan over the
// kept slots.
// The response register frees the datapath; if the receiver stalls, a
// finished result waits in the sequencer until the register drains.
// Reset clears the slot valid bits, planar marks, configuration and all
// control state; table contents are undefined until written.
module geographic_next_hop_select_unit #(
    parameter int NEIGHBORS = gnh_pkg::NEIGHBORS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gnh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gnh_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  gnh_pkg::gnh_req_t                   req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output gnh_pkg::gnh_rsp_t                   rsp
);

    localparam int CB  = gnh_pkg::COORD_BITS;
    localparam int IDW = gnh_pkg::ID_W;
    localparam int MW  = gnh_pkg::MW;
    localparam int PW  = gnh_pkg::PW;
    localparam int AW  = gnh_pkg::AW;
    localparam int IW  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int SW  = (IW > gnh_pkg::SLOT_W) ? IW : gnh_pkg::SLOT_W;
    localparam int EW  = IDW + 2 * CB;
    localparam logic [IW-1:0] LAST_IDX = IW'(NEIGHBORS - 1);

    // Control state.
    gnh_pkg::gnh_state_t state_reg, state_next;
    logic [2:0]          sub_reg, sub_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [IW-1:0]       w_reg, w_next;
    logic [NEIGHBORS-1:0] valid_reg, valid_next;
    logic [NEIGHBORS-1:0] mark_reg, mark_next;
    logic                best_valid_reg, best_valid_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic signed [CB-1:0] own_x_reg, own_y_reg;
    logic                use_gabriel_reg;

    // Datapath registers.
    logic signed [CB-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [CB-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [MW-1:0] refx_reg, refx_next, refy_reg, refy_next;
    logic signed [MW-1:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] own_d_reg, own_d_next;
    logic signed [AW-1:0] best_d_reg, best_d_next;
    logic signed [AW-1:0] cd_reg, cd_next;
    logic signed [AW-1:0] d1_reg, d1_next;
    logic [IDW-1:0]       best_id_reg, best_id_next;
    logic                 best_half_reg, best_half_next;
    logic                 half_reg, half_next;
    logic                 cpos_reg, cpos_next;
    logic                 czero_reg, czero_next;
    logic                 keep_reg, keep_next;
    gnh_pkg::gnh_rsp_t    res_reg, res_next;
    gnh_pkg::gnh_rsp_t    rsp_reg, rsp_next;

    // Neighbor table.
    logic [EW-1:0] tbl_mem [NEIGHBORS];
    logic [EW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [SW-1:0] slot_ext;
    logic          slot_ok;
    logic          tbl_we;

    logic [IDW-1:0]       rd_id;
    logic signed [CB-1:0] rd_x, rd_y;
    logic signed [MW-1:0] nx_e, ny_e, ox_e, oy_e, px_e, py_e, cx_e, cy_e, ax_e, ay_e;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [AW-1:0] sum, diff;
    logic                 usable, last_i, last_w;

    assign req_stall = (state_reg != gnh_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign slot_ext = SW'(req.slot);
    assign wr_addr  = slot_ext[IW-1:0];
    assign slot_ok  = (int'(req.slot) < NEIGHBORS);

    assign rd_id = rd_data_reg[EW-1:2*CB];
    assign rd_x  = rd_data_reg[2*CB-1:CB];
    assign rd_y  = rd_data_reg[CB-1:0];

    assign nx_e = gnh_pkg::ext(rd_x);
    assign ny_e = gnh_pkg::ext(rd_y);
    assign ox_e = gnh_pkg::ext(own_x_reg);
    assign oy_e = gnh_pkg::ext(own_y_reg);
    assign px_e = gnh_pkg::ext(qx_reg);
    assign py_e = gnh_pkg::ext(qy_reg);
    assign cx_e = gnh_pkg::ext(cx_reg);
    assign cy_e = gnh_pkg::ext(cy_reg);
    assign ax_e = nx_e - ox_e;
    assign ay_e = ny_e - oy_e;

    assign rd_addr = (state_reg == gnh_pkg::ST_PL_W) ? w_reg : i_reg;
    assign usable  = valid_reg[rd_addr] && !(rd_x == own_x_reg && rd_y == own_y_reg);
    assign last_i  = (i_reg == LAST_IDX);
    assign last_w  = (w_reg == LAST_IDX);

    assign sum  = acc_reg + gnh_pkg::pext(prod_reg);
    assign diff = acc_reg - gnh_pkg::pext(prod_reg);

    assign prod_next = mul_a * mul_b;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            gnh_pkg::ST_OWN:
            begin
                if (sub_reg == 3'd0)
                begin
                    mul_a = ox_e - px_e;
                    mul_b = ox_e - px_e;
                end
                else
                begin
                    mul_a = oy_e - py_e;
                    mul_b = oy_e - py_e;
                end
            end
            gnh_pkg::ST_GREEDY:
            begin
                if (sub_reg == 3'd1)
                begin
                    mul_a = nx_e - px_e;
                    mul_b = nx_e - px_e;
                end
                else
                begin
                    mul_a = ny_e - py_e;
                    mul_b = ny_e - py_e;
                end
            end
            gnh_pkg::ST_PL_D:
            begin
                if (sub_reg == 3'd1)
                begin
                    mul_a = ax_e;
                    mul_b = ax_e;
                end
                else
                begin
                    mul_a = ay_e;
                    mul_b = ay_e;
                end
            end
            gnh_pkg::ST_PL_W:
            begin
                if (use_gabriel_reg)
                begin
                    // Squared distance from the witness to the midpoint, scaled by 4.
                    if (sub_reg == 3'd1)
                    begin
                        mul_a = (nx_e <<< 1) - ox_e - cx_e;
                        mul_b = (nx_e <<< 1) - ox_e - cx_e;
                    end
                    else
                    begin
                        mul_a = (ny_e <<< 1) - oy_e - cy_e;
                        mul_b = (ny_e <<< 1) - oy_e - cy_e;
                    end
                end
                else
                begin
                    case (sub_reg)
                        3'd1:
                        begin
                            mul_a = ax_e;
                            mul_b = ax_e;
                        end
                        3'd2:
                        begin
                            mul_a = ay_e;
                            mul_b = ay_e;
                        end
                        3'd3:
                        begin
                            mul_a = cx_e - nx_e;
                            mul_b = cx_e - nx_e;
                        end
                        default:
                        begin
                            mul_a = cy_e - ny_e;
                            mul_b = cy_e - ny_e;
                        end
                    endcase
                end
            end
            gnh_pkg::ST_PER:
            begin
                case (sub_reg)
                    3'd1:
                    begin
                        mul_a = refx_reg;
                        mul_b = ay_e;
                    end
                    3'd2:
                    begin
                        mul_a = refy_reg;
                        mul_b = ax_e;
                    end
                    3'd3:
                    begin
                        mul_a = refx_reg;
                        mul_b = ax_e;
                    end
                    3'd4:
                    begin
                        mul_a = refy_reg;
                        mul_b = ay_e;
                    end
                    3'd5:
                    begin
                        mul_a = ax_e;
                        mul_b = by_reg;
                    end
                    default:
                    begin
                        mul_a = ay_e;
                        mul_b = bx_reg;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gnh_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req.opcode == gnh_pkg::OP_WRITE) ?
                                 gnh_pkg::ST_DONE : gnh_pkg::ST_OWN;
                end
            end
            gnh_pkg::ST_OWN:
            begin
                if (sub_reg == 3'd2)
                begin
                    state_next = gnh_pkg::ST_GREEDY;
                end
            end
            gnh_pkg::ST_GREEDY:
            begin
                if (last_i && ((sub_reg == 3'd1 && !usable) || sub_reg == 3'd3))
                begin
                    state_next = gnh_pkg::ST_G_END;
                end
            end
            gnh_pkg::ST_G_END:
            begin
                state_next = best_valid_reg ? gnh_pkg::ST_DONE : gnh_pkg::ST_PL_D;
            end
            gnh_pkg::ST_PL_D:
            begin
                if (sub_reg == 3'd1 && !usable && last_i)
                begin
                    state_next = gnh_pkg::ST_PER;
                end
                else if (sub_reg == 3'd3)
                begin
                    state_next = gnh_pkg::ST_PL_W;
                end
            end
            gnh_pkg::ST_PL_W:
            begin
                if (last_w && ((sub_reg == 3'd1 && (w_reg == i_reg || !usable)) ||
                               (sub_reg == 3'd3 && use_gabriel_reg) || sub_reg == 3'd5))
                begin
                    state_next = last_i ? gnh_pkg::ST_PER : gnh_pkg::ST_PL_D;
                end
            end
            gnh_pkg::ST_PER:
            begin
                if (last_i && ((sub_reg == 3'd1 && !mark_reg[i_reg]) || sub_reg == 3'd7))
                begin
                    state_next = gnh_pkg::ST_P_END;
                end
            end
            gnh_pkg::ST_P_END:
            begin
                state_next = gnh_pkg::ST_DONE;
            end
            gnh_pkg::ST_DONE:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    state_next = gnh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gnh_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and counters.
    always_comb
    begin
        logic kill;
        logic before_ib;
        logic before_bi;

        kill            = 1'b0;
        before_ib       = 1'b0;
        before_bi       = 1'b0;
        sub_next        = sub_reg + 3'd1;
        i_next          = i_reg;
        w_next          = w_reg;
        valid_next      = valid_reg;
        mark_next       = mark_reg;
        best_valid_next = best_valid_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        refx_next       = refx_reg;
        refy_next       = refy_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        acc_next        = acc_reg;
        own_d_next      = own_d_reg;
        best_d_next     = best_d_reg;
        cd_next         = cd_reg;
        d1_next         = d1_reg;
        best_id_next    = best_id_reg;
        best_half_next  = best_half_reg;
        half_next       = half_reg;
        cpos_next       = cpos_reg;
        czero_next      = czero_reg;
        keep_next       = keep_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        tbl_we          = 1'b0;

        case (state_reg)
            gnh_pkg::ST_IDLE:
            begin
                sub_next = 3'd0;
                if (req_valid)
                begin
                    res_next = '0;
                    qx_next  = req.pos_x;
                    qy_next  = req.pos_y;
                    if (req.opcode == gnh_pkg::OP_WRITE && slot_ok)
                    begin
                        tbl_we              = 1'b1;
                        valid_next[wr_addr] = req.entry_valid;
                    end
                end
            end
            gnh_pkg::ST_OWN:
            begin
                if (sub_reg == 3'd0)
                begin
                    // A destination at our own position uses the +x direction.
                    refx_next = px_e - ox_e;
                    refy_next = py_e - oy_e;
                    if (px_e == ox_e && py_e == oy_e)
                    begin
                        refx_next = MW'(1);
                    end
                end
                else if (sub_reg == 3'd1)
                begin
                    acc_next = gnh_pkg::pext(prod_reg);
                end
                else
                begin
                    own_d_next      = sum;
                    sub_next        = 3'd0;
                    i_next          = '0;
                    best_valid_next = 1'b0;
                end
            end
            gnh_pkg::ST_GREEDY:
            begin
                if ((sub_reg == 3'd1 && !usable) || sub_reg == 3'd3)
                begin
                    if (sub_reg == 3'd3 && sum < own_d_reg &&
                        (!best_valid_reg || sum < best_d_reg ||
                         (sum == best_d_reg && rd_id < best_id_reg)))
                    begin
                        best_valid_next = 1'b1;
                        best_d_next     = sum;
                        best_id_next    = rd_id;
                    end
                    sub_next = 3'd0;
                    if (!last_i)
                    begin
                        i_next = i_reg + IW'(1);
                    end
                end
                else if (sub_reg == 3'd2)
                begin
                    acc_next = gnh_pkg::pext(prod_reg);
                end
            end
            gnh_pkg::ST_G_END:
            begin
                sub_next = 3'd0;
                i_next   = '0;
                if (best_valid_reg)
                begin
                    res_next.next_hop       = best_id_reg;
                    res_next.found          = 1'b1;
                    res_next.used_perimeter = 1'b0;
                end
            end
            gnh_pkg::ST_PL_D:
            begin
                case (sub_reg)
                    3'd1:
                    begin
                        cx_next = rd_x;
                        cy_next = rd_y;
                        if (!usable)
                        begin
                            mark_next[i_reg] = 1'b0;
                            sub_next         = 3'd0;
                            if (last_i)
                            begin
                                i_next          = '0;
                                best_valid_next = 1'b0;
                            end
                            else
                            begin
                                i_next = i_reg + IW'(1);
                            end
                        end
                    end
                    3'd2:
                    begin
                        acc_next = gnh_pkg::pext(prod_reg);
                    end
                    3'd3:
                    begin
                        cd_next   = sum;
                        keep_next = 1'b1;
                        w_next    = '0;
                        sub_next  = 3'd0;
                    end
                    default:
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                endcase
            end
            gnh_pkg::ST_PL_W:
            begin
                if ((sub_reg == 3'd1 && (w_reg == i_reg || !usable)) ||
                    (sub_reg == 3'd3 && use_gabriel_reg) || sub_reg == 3'd5)
                begin
                    if (sub_reg == 3'd3)
                    begin
                        kill = (sum < cd_reg);
                    end
                    else if (sub_reg == 3'd5)
                    begin
                        kill = (d1_reg < cd_reg) && (sum < cd_reg);
                    end
                    keep_next = keep_reg && !kill;
                    sub_next  = 3'd0;
                    if (last_w)
                    begin
                        mark_next[i_reg] = keep_reg && !kill;
                        if (last_i)
                        begin
                            i_next          = '0;
                            best_valid_next = 1'b0;
                        end
                        else
                        begin
                            i_next = i_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        w_next = w_reg + IW'(1);
                    end
                end
                else if (sub_reg == 3'd2 || sub_reg == 3'd4)
                begin
                    acc_next = gnh_pkg::pext(prod_reg);
                end
                else if (sub_reg == 3'd3)
                begin
                    d1_next = sum;
                end
            end
            gnh_pkg::ST_PER:
            begin
                case (sub_reg)
                    3'd1:
                    begin
                        if (!mark_reg[i_reg])
                        begin
                            sub_next = 3'd0;
                            if (!last_i)
                            begin
                                i_next = i_reg + IW'(1);
                            end
                        end
                    end
                    3'd2, 3'd4, 3'd6:
                    begin
                        acc_next = gnh_pkg::pext(prod_reg);
                    end
                    3'd3:
                    begin
                        cpos_next  = (diff > 0);
                        czero_next = (diff == 0);
                    end
                    3'd5:
                    begin
                        // Half plane 0 covers angles in [0, pi) from the reference.
                        half_next = !(cpos_reg || (czero_reg && sum > 0));
                    end
                    3'd7:
                    begin
                        if (half_reg != best_half_reg)
                        begin
                            before_ib = (half_reg < best_half_reg);
                            before_bi = (best_half_reg < half_reg);
                        end
                        else
                        begin
                            before_ib = (diff > 0);
                            before_bi = (diff < 0);
                        end
                        if (!best_valid_reg || before_ib ||
                            (!before_bi && rd_id < best_id_reg))
                        begin
                            best_valid_next = 1'b1;
                            best_id_next    = rd_id;
                            best_half_next  = half_reg;
                            bx_next         = ax_e;
                            by_next         = ay_e;
                        end
                        sub_next = 3'd0;
                        if (!last_i)
                        begin
                            i_next = i_reg + IW'(1);
                        end
                    end
                    default:
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                endcase
            end
            gnh_pkg::ST_P_END:
            begin
                res_next.next_hop       = best_valid_reg ? best_id_reg : '0;
                res_next.found          = best_valid_reg;
                res_next.used_perimeter = 1'b1;
            end
            gnh_pkg::ST_DONE:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                sub_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gnh_pkg::ST_IDLE;
            sub_reg         <= '0;
            i_reg           <= '0;
            w_reg           <= '0;
            valid_reg       <= '0;
            mark_reg        <= '0;
            best_valid_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            own_x_reg       <= '0;
            own_y_reg       <= '0;
            use_gabriel_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sub_reg        <= sub_next;
            i_reg          <= i_next;
            w_reg          <= w_next;
            valid_reg      <= valid_next;
            mark_reg       <= mark_next;
            best_valid_reg <= best_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    gnh_pkg::CFG_OWN_X:       own_x_reg       <= cfg_data[CB-1:0];
                    gnh_pkg::CFG_OWN_Y:       own_y_reg       <= cfg_data[CB-1:0];
                    gnh_pkg::CFG_USE_GABRIEL: use_gabriel_reg <= cfg_data[0];
                    default:                  use_gabriel_reg <= use_gabriel_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        refx_reg      <= refx_next;
        refy_reg      <= refy_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        own_d_reg     <= own_d_next;
        best_d_reg    <= best_d_next;
        cd_reg        <= cd_next;
        d1_reg        <= d1_next;
        best_id_reg   <= best_id_next;
        best_half_reg <= best_half_next;
        half_reg      <= half_next;
        cpos_reg      <= cpos_next;
        czero_reg     <= czero_next;
        keep_reg      <= keep_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    // Neighbor table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[wr_addr] <= {req.entry_id, req.pos_x, req.pos_y};
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

endmodule

>>> bench/tb.sv
// Self-checking bench for geographic_next_hop_select_unit: directed table, then random
// write/query traffic under several own-position and planarization settings.
// Depends on gnh_pkg and the unit's RTL only.
module tb;

    localparam int  SLOTS       = gnh_pkg::NEIGHBORS_DEF;
    localparam int  CYCLE_LIMIT = 10000000;
    localparam int  DRAIN       = 2500;
    localparam int  HOLD_CYCLES = 4000;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    logic [gnh_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gnh_pkg::CFG_DATA_W-1:0] cfg_data;
    logic     req_valid;
    logic     req_stall;
    gnh_pkg::gnh_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    gnh_pkg::gnh_rsp_t rsp;

    // Typed expectation that travels with the driven transaction.
    logic              req_typed;
    gnh_pkg::gnh_rsp_t req_hop;

    // Copies of the unit's outputs taken at the falling edge, read at the rising edge.
    logic     req_stall_s;
    logic     rsp_valid_s;
    gnh_pkg::gnh_rsp_t rsp_s;

    geographic_next_hop_select_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // Mirror of the neighbor table and configuration.
    logic    nb_valid [SLOTS];
    logic [gnh_pkg::ID_W-1:0] nb_id [SLOTS];
    longint  nb_x [SLOTS];
    longint  nb_y [SLOTS];
    logic    nb_planar [SLOTS];
    longint  node_x;
    longint  node_y;
    logic    gabriel_mode;

    gnh_pkg::gnh_rsp_t hop_q[$];
    int       errors;
    int       n_query;
    int       n_perimeter;
    int       n_found;
    int       n_rsp;
    longint   cycles;
    logic     no_idle;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        req_stall_s <= req_stall;
        rsp_valid_s <= rsp_valid;
        rsp_s       <= rsp;
    end

    function automatic longint sq(input longint d);
        sq = d * d;
    endfunction

    function automatic logic usable(input int i);
        usable = nb_valid[i] && !(nb_x[i] == node_x && nb_y[i] == node_y);
    endfunction

    // 0 when the angle from the reference lies in [0, pi), 1 otherwise.
    function automatic int half_plane(input longint rx, ry, vx, vy);
        longint c;
        longint d;
        c = rx * vy - ry * vx;
        d = rx * vx + ry * vy;
        half_plane = (c > 0 || (c == 0 && d > 0)) ? 0 : 1;
    endfunction

    function automatic logic ccw_earlier(input longint rx, ry, input int a, b);
        longint ax;
        longint ay;
        longint bx;
        longint by;
        int     ha;
        int     hb;
        ax = nb_x[a] - node_x;
        ay = nb_y[a] - node_y;
        bx = nb_x[b] - node_x;
        by = nb_y[b] - node_y;
        ha = half_plane(rx, ry, ax, ay);
        hb = half_plane(rx, ry, bx, by);
        if (ha != hb)
            ccw_earlier = ha < hb;
        else
            ccw_earlier = ax * by - ay * bx > 0;
    endfunction

    // Applies one transaction to the mirror and returns the hop the unit must report.
    function automatic gnh_pkg::gnh_rsp_t next_hop_of(input gnh_pkg::gnh_req_t r);
        gnh_pkg::gnh_rsp_t o;
        longint   px;
        longint   py;
        longint   own_d;
        longint   d;
        longint   best_d;
        longint   rx;
        longint   ry;
        int       best;
        logic     keep;
        o  = '0;
        px = longint'(r.pos_x);
        py = longint'(r.pos_y);
        if (r.opcode == gnh_pkg::OP_WRITE)
        begin
            nb_valid[r.slot] = r.entry_valid;
            nb_id[r.slot]    = r.entry_id;
            nb_x[r.slot]     = px;
            nb_y[r.slot]     = py;
            return o;
        end
        own_d  = sq(node_x - px) + sq(node_y - py);
        best   = -1;
        best_d = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!usable(i))
                continue;
            d = sq(nb_x[i] - px) + sq(nb_y[i] - py);
            if (d >= own_d)
                continue;
            if (best < 0 || d < best_d || (d == best_d && nb_id[i] < nb_id[best]))
            begin
                best   = i;
                best_d = d;
            end
        end
        if (best >= 0)
        begin
            o.next_hop = nb_id[best];
            o.found    = 1'b1;
            return o;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            keep = usable(i);
            if (keep)
            begin
                d = sq(nb_x[i] - node_x) + sq(nb_y[i] - node_y);
                for (int w = 0; w < SLOTS; w++)
                begin
                    if (w == i || !usable(w))
                        continue;
                    if (gabriel_mode)
                    begin
                        if (sq(2 * nb_x[w] - node_x - nb_x[i])
                            + sq(2 * nb_y[w] - node_y - nb_y[i]) < d)
                            keep = 1'b0;
                    end
                    else if (sq(nb_x[w] - node_x) + sq(nb_y[w] - node_y) < d &&
                             sq(nb_x[i] - nb_x[w]) + sq(nb_y[i] - nb_y[w]) < d)
                        keep = 1'b0;
                end
            end
            nb_planar[i] = keep;
        end
        rx = px - node_x;
        ry = py - node_y;
        if (rx == 0 && ry == 0)
            rx = 1;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!nb_planar[i])
                continue;
            if (best < 0 || ccw_earlier(rx, ry, i, best) ||
                (!ccw_earlier(rx, ry, best, i) && nb_id[i] < nb_id[best]))
                best = i;
        end
        o.used_perimeter = 1'b1;
        if (best >= 0)
        begin
            o.next_hop = nb_id[best];
            o.found    = 1'b1;
        end
        return o;
    endfunction

    // Request side: predict on every accepted transaction; a typed hop overrides it.
    always @(posedge clk)
    begin
        gnh_pkg::gnh_rsp_t p;
        if (rst_n && req_valid && !req_stall_s)
        begin
            p = next_hop_of(req);
            if (req_typed)
                p = req_hop;
            hop_q = {hop_q, p};
        end
    end

    // Response side: compare with the oldest expectation.
    always @(posedge clk)
    begin
        gnh_pkg::gnh_rsp_t e;
        if (rst_n && rsp_valid_s && !rsp_stall)
        begin
            n_rsp++;
            if (hop_q.size() == 0)
            begin
                $display("%0t unexpected response: expected none, got %h", $time, rsp_s);
                errors++;
            end
            else
            begin
                e = hop_q.pop_front();
                if (e.used_perimeter)
                    n_perimeter++;
                if (e.found)
                    n_found++;
                if (rsp_s.next_hop !== e.next_hop)
                begin
                    $display("%0t next_hop: expected %h, got %h", $time, e.next_hop,
                             rsp_s.next_hop);
                    errors++;
                end
                if (rsp_s.found !== e.found)
                begin
                    $display("%0t found: expected %b, got %b", $time, e.found, rsp_s.found);
                    errors++;
                end
                if (rsp_s.used_perimeter !== e.used_perimeter)
                begin
                    $display("%0t used_perimeter: expected %b, got %b", $time,
                             e.used_perimeter, rsp_s.used_perimeter);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                     hop_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // Receiver: random back-pressure per transaction, one long hold-off early on.
    initial
    begin
        int k;
        logic held;
        held = 1'b0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && n_rsp >= 300)
            begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            k = no_idle ? 0 : $urandom_range(0, 4);
            if (k > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid_s);
        end
    end

    task automatic send(input gnh_pkg::gnh_req_t r, input logic typed,
                        input gnh_pkg::gnh_rsp_t hop);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        req_typed <= typed;
        req_hop   <= hop;
        @(posedge clk);
        while (req_stall_s)
            @(posedge clk);
    endtask

    // Waits until every transaction has its response, then writes the configuration.
    task automatic set_node(input logic [15:0] x, y, input logic g);
        req_valid <= 1'b0;
        @(posedge clk);
        while (hop_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= gnh_pkg::CFG_OWN_X;
        cfg_data  <= x;
        @(posedge clk);
        cfg_index <= gnh_pkg::CFG_OWN_Y;
        cfg_data  <= y;
        @(posedge clk);
        cfg_index <= gnh_pkg::CFG_USE_GABRIEL;
        cfg_data  <= {15'd0, g};
        @(posedge clk);
        cfg_we <= 1'b0;
        node_x = longint'($signed(x));
        node_y = longint'($signed(y));
        gabriel_mode = g;
    endtask

    // Mostly near the node so that ties, near misses and crowded tables occur.
    function automatic logic [15:0] coord(input longint center);
        if ($urandom_range(0, 9) < 7)
            coord = 16'(center + $urandom_range(0, 16) - 8);
        else
            coord = 16'($urandom);
    endfunction

    typedef struct {
        gnh_pkg::gnh_req_t r;
        logic              typed;
        gnh_pkg::gnh_rsp_t hop;
    } row_t;

    function automatic row_t mk(input logic op, input logic [3:0] s, input logic v,
                                input logic [15:0] id, x, y, input logic typed,
                                input logic [15:0] hop, input logic f, p);
        mk.r     = '{opcode: op, slot: s, entry_valid: v, entry_id: id, pos_x: x, pos_y: y};
        mk.typed = typed;
        mk.hop   = '{next_hop: hop, found: f, used_perimeter: p};
    endfunction

    initial
    begin
        row_t     rows[$];
        gnh_pkg::gnh_req_t r;
        int       nw;
        int       nq;
        int       sent;
        logic [15:0] cx [6];
        logic [15:0] cy [6];
        logic        cg [6];

        errors = 0; n_query = 0; n_perimeter = 0; n_found = 0; n_rsp = 0;
        cycles = 0; no_idle = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = gnh_pkg::CFG_OWN_X; cfg_data = '0;
        req_valid = 1'b0; req = '0; req_typed = 1'b0; req_hop = '0;
        node_x = 0; node_y = 0; gabriel_mode = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            nb_valid[i] = 1'b0; nb_id[i] = '0; nb_x[i] = 0; nb_y[i] = 0;
            nb_planar[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; a typed hop replaces the predicted one.
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, 16'd5, 16'd5, 1, 16'd0, 0, 1)};
        rows = {rows, mk(gnh_pkg::OP_WRITE, 4'd0, 1, 16'hFFFF, 16'd1, 16'd0, 1, 16'd0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, 16'd100, 16'd0, 1, 16'hFFFF, 1, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, 16'd0, 16'd0, 1, 16'hFFFF, 1, 1)};
        rows = {rows, mk(gnh_pkg::OP_WRITE, 4'd1, 1, 16'd5, 16'd0, 16'd0, 1, 16'd0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, -16'sd100, 16'd0, 1,
                         16'hFFFF, 1, 1)};
        rows = {rows, mk(gnh_pkg::OP_WRITE, 4'd15, 1, 16'd0, 16'h8000, 16'h8000, 1,
                         16'd0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, 16'h8000, 16'h8000, 1,
                         16'd0, 1, 0)};
        rows = {rows, mk(gnh_pkg::OP_WRITE, 4'd2, 1, 16'd7, 16'h7FFF, 16'h7FFF, 1,
                         16'd0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'hF, 1, 16'hFFFF, 16'h7FFF, 16'h8000, 0,
                         0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_WRITE, 4'd3, 1, 16'd3, 16'd0, 16'd1, 1, 16'd0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_WRITE, 4'd4, 1, 16'd3, 16'd0, -16'sd1, 1, 16'd0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, 16'd0, 16'd5, 0, 0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, 16'd5, 16'd0, 0, 0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_WRITE, 4'd5, 1, 16'd2, -16'sd1, 16'd0, 1, 16'd0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, -16'sd1, -16'sd1, 0, 0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_WRITE, 4'd0, 0, 16'h1234, 16'd1, 16'd0, 1, 16'd0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, 16'd100, 16'd0, 0, 0, 0, 0)};
        rows = {rows, mk(gnh_pkg::OP_QUERY, 4'd0, 0, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0)};
        foreach (rows[i])
            send(rows[i].r, rows[i].typed, rows[i].hop);

        cx = '{16'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd0};
        cy = '{16'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0};
        cg = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        cx[5] = 16'($urandom);
        cy[5] = 16'($urandom);
        cg[5] = 1'($urandom);
        sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            set_node(cx[ph], cy[ph], cg[ph]);
            while (sent < (ph + 1) * 205)
            begin
                no_idle = (sent >= 600 && sent < 750);
                nw = $urandom_range(1, 4);
                nq = $urandom_range(1, 3);
                for (int k = 0; k < nw + nq; k++)
                begin
                    r.opcode      = (k < nw) ? gnh_pkg::OP_WRITE : gnh_pkg::OP_QUERY;
                    if ($urandom_range(0, 19) == 0)
                        r.opcode  = ~r.opcode;
                    r.slot        = 4'($urandom);
                    r.entry_valid = ($urandom_range(0, 9) < 8);
                    r.entry_id    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7))
                                                               : 16'($urandom);
                    r.pos_x       = coord(node_x);
                    r.pos_y       = coord(node_y);
                    if (r.opcode == gnh_pkg::OP_QUERY)
                        n_query++;
                    send(r, 1'b0, '0);
                    sent++;
                end
            end
        end
        req_valid <= 1'b0;
        no_idle = 1'b0;
        @(posedge clk);

        while (hop_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d random transactions after the directed table, %0d of them queries,",
                 sent, n_query);
        $display("%0d perimeter decisions, %0d hops found, six node settings",
                 n_perimeter, n_found);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
src/gnh_pkg.sv
src/geographic_next_hop_select_unit.sv
bench/tb.sv
